### rtl/core/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the sobel edge magnitude unit
// pixel and gradient widths, register codes, window and kernel select types
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W            = 8;
    localparam int MAG_W            = 8;
    // |gx|,|gy| <= 4*255, signed
    localparam int GRAD_W           = PIX_W + 3;
    // gx^2 + gy^2 <= 2*1020^2
    localparam int SUM_W            = 2 * (GRAD_W - 1) + 1;
    localparam int FRAME_WIDTH_W    = 11;
    localparam int FRAME_HEIGHT_W   = 13;
    localparam int CFG_W            = 13;
    localparam int CFG_IDX_W        = 1;
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 4096;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int MAG_SAT          = 2 ** MAG_W - 1;
    // largest sum whose rounded root still does not exceed saturation
    localparam int ROOT_CAP_SUM     = MAG_SAT * (MAG_SAT + 1);
    localparam int WIN_N            = 9;
    localparam int WIN_IDX_W        = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } sem_reg_idx_t;

    // 3x3 window, row-major, rows oldest to newest, columns oldest to newest
    typedef logic [WIN_N-1:0][PIX_W-1:0] sem_win_t;

    // window rows (top, middle, bottom) and columns (left, center, right)
    typedef struct packed {
        logic [1:0] rt;
        logic [1:0] rm;
        logic [1:0] rb;
        logic [1:0] cl;
        logic [1:0] cm;
        logic [1:0] cr;
    } sem_sel_t;

endpackage

### rtl/core/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram: generic single-port-write, single-port-read ram
// one write and one read per cycle, read data registered
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/sem_grad.sv
// ----------------------------------------------------------------------------
// sem_grad: sobel gradients and squared magnitude
// two stages: gx/gy from the selected window taps, then gx^2 + gy^2
// ----------------------------------------------------------------------------
module sem_grad (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  sem_pkg::sem_sel_t         sel,
    input  sem_pkg::sem_win_t         win,
    output logic [sem_pkg::SUM_W-1:0] sum,
    output logic                      sum_valid
);

    import sem_pkg::*;

    logic signed [GRAD_W-1:0]   gx;
    logic signed [GRAD_W-1:0]   gy;
    logic signed [GRAD_W-1:0]   gx_reg;
    logic signed [GRAD_W-1:0]   gy_reg;
    logic signed [2*GRAD_W-1:0] sqx;
    logic signed [2*GRAD_W-1:0] sqy;
    logic [SUM_W-1:0]           sum_reg;
    logic                       v1_reg;
    logic                       v2_reg;

    function automatic logic signed [GRAD_W-1:0] tap(sem_win_t w, logic [1:0] r,
                                                     logic [1:0] c);
        logic [WIN_IDX_W-1:0] idx;
        idx = WIN_IDX_W'(r) * WIN_IDX_W'(3) + WIN_IDX_W'(c);
        return $signed(GRAD_W'(w[idx]));
    endfunction

    always_comb
    begin
        gx = (tap(win, sel.rt, sel.cl) + (tap(win, sel.rm, sel.cl) <<< 1)
              + tap(win, sel.rb, sel.cl))
           - (tap(win, sel.rt, sel.cr) + (tap(win, sel.rm, sel.cr) <<< 1)
              + tap(win, sel.rb, sel.cr));
        gy = (tap(win, sel.rt, sel.cl) + (tap(win, sel.rt, sel.cm) <<< 1)
              + tap(win, sel.rt, sel.cr))
           - (tap(win, sel.rb, sel.cl) + (tap(win, sel.rb, sel.cm) <<< 1)
              + tap(win, sel.rb, sel.cr));
        sqx = gx_reg * gx_reg;
        sqy = gy_reg * gy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            gx_reg  <= '0;
            gy_reg  <= '0;
            sum_reg <= '0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            if (start)
            begin
                gx_reg <= gx;
                gy_reg <= gy;
            end
            if (v1_reg)
            begin
                // both squares are non-negative and below 2^20
                sum_reg <= SUM_W'(sqx) + SUM_W'(sqy);
            end
        end
    end

    assign sum       = sum_reg;
    assign sum_valid = v2_reg;

endmodule

### rtl/core/sem_root.sv
// ----------------------------------------------------------------------------
// sem_root: rounded square root, saturated
// one result bit per cycle, then a rounding step: n*n-n+1 <= s <= n*n+n
// ----------------------------------------------------------------------------
module sem_root (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sem_pkg::SUM_W-1:0] radicand,
    output logic [sem_pkg::MAG_W-1:0] root,
    output logic                      done
);

    import sem_pkg::*;

    localparam int BIT_W = $clog2(MAG_W);
    localparam int LIM_W = 2 * MAG_W + 1;

    typedef enum logic [1:0] {
        R_IDLE,
        R_RUN,
        R_FIX
    } rstate_t;

    rstate_t            state_reg;
    logic [SUM_W-1:0]   rad_reg;
    logic [MAG_W-1:0]   root_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               done_reg;
    logic [MAG_W-1:0]   trial;
    logic [2*MAG_W-1:0] trial_sq;
    logic [LIM_W-1:0]   lim;

    always_comb
    begin
        trial    = root_reg | (MAG_W'(1) << bit_reg);
        trial_sq = (2*MAG_W)'(trial) * (2*MAG_W)'(trial);
        lim      = LIM_W'(root_reg) * LIM_W'(root_reg) + LIM_W'(root_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            rad_reg   <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                R_IDLE:
                begin
                    done_reg <= start && (radicand > SUM_W'(ROOT_CAP_SUM));
                    if (start)
                    begin
                        rad_reg <= radicand;
                        if (radicand > SUM_W'(ROOT_CAP_SUM))
                        begin
                            root_reg <= MAG_W'(MAG_SAT);
                        end
                        else
                        begin
                            root_reg  <= '0;
                            bit_reg   <= BIT_W'(MAG_W - 1);
                            state_reg <= R_RUN;
                        end
                    end
                end
                R_RUN:
                begin
                    done_reg <= 1'b0;
                    if (SUM_W'(trial_sq) <= rad_reg)
                    begin
                        root_reg <= trial;
                    end
                    if (bit_reg == '0)
                    begin
                        state_reg <= R_FIX;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - BIT_W'(1);
                    end
                end
                R_FIX:
                begin
                    // round up when s lies above n*n+n; never passes saturation here
                    if (rad_reg > SUM_W'(lim))
                    begin
                        root_reg <= root_reg + MAG_W'(1);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= R_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### rtl/core/sobel_edge_magnitude_3x3_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_unit: streaming 3x3 sobel edge magnitude
// line stores in ram, 3x3 window, shared gradient unit and iterative root
// ----------------------------------------------------------------------------
// Pixels come in raster order over a frame of frame_width by frame_height
// (clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT); border pixels are replicated.
// Each pixel gives zero to three words tagged with row and column, the last
// one flagged by last_in_run; the bottom-right word of a frame comes out with
// the first pixel of the next frame. The two previous rows live in one
// MAX_WIDTH x 16 ram, read when a pixel is taken and written back the cycle
// after; the ram needs no clearing pass. One pixel is worked on at a time:
// each word it computes passes the shared gradient unit (2 stages) and then
// the bit-serial square root, which handle one word after the other; the root
// skips its iterations when the sum saturates, a held word skips both, and a
// stalled output holds the unit in ST_EMIT. The next pixel is
// taken while the last word still waits in the output register.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_unit #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sem_pkg::PIX_W-1:0]     pixel_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sem_pkg::MAG_W-1:0]     edge_magnitude,
    output logic [$clog2(MAX_HEIGHT)-1:0] out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
    output logic                          last_in_run
);

    import sem_pkg::*;

    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCMP   = ((FRAME_WIDTH_W > COL_W) ? FRAME_WIDTH_W : COL_W) + 1;
    localparam int HCMP   = ((FRAME_HEIGHT_W > ROW_W) ? FRAME_HEIGHT_W : ROW_W) + 1;
    localparam int LINE_W = 2 * PIX_W;
    localparam int CAND_N = 5;

    // candidate words of one pixel, in output order
    localparam int CAND_HELD = 0;
    localparam int CAND_UP   = 1;
    localparam int CAND_UPR  = 2;
    localparam int CAND_CUR  = 3;
    localparam int CAND_CURR = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PICK,
        ST_GRAD,
        ST_ROOT,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [FRAME_WIDTH_W-1:0]  fw_reg;
    logic [FRAME_HEIGHT_W-1:0] fh_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [COL_W-1:0]          col_reg;
    logic [ROW_W-1:0]          item_row_reg;
    logic [COL_W-1:0]          item_col_reg;
    logic                      last_col_reg;
    logic                      last_row_reg;
    logic [PIX_W-1:0]          pix_reg;
    sem_win_t                  win_reg;
    logic [CAND_N-1:0]         pres_reg;
    logic [1:0]                emit_cnt_reg;
    logic                      held_valid_reg;
    logic [MAG_W-1:0]          held_mag_reg;
    logic [ROW_W-1:0]          held_row_reg;
    logic [COL_W-1:0]          held_col_reg;
    logic [MAG_W-1:0]          cur_mag_reg;
    logic [ROW_W-1:0]          cur_row_reg;
    logic [COL_W-1:0]          cur_col_reg;
    logic                      out_valid_reg;
    logic [MAG_W-1:0]          out_mag_reg;
    logic [ROW_W-1:0]          out_row_reg;
    logic [COL_W-1:0]          out_col_reg;
    logic                      out_last_reg;

    logic [WCMP-1:0]   fw_ext;
    logic [WCMP-1:0]   w_eff;
    logic [HCMP-1:0]   fh_ext;
    logic [HCMP-1:0]   h_eff;
    logic              col_last;
    logic              row_last;
    logic              accept;
    logic              out_free;
    logic [CAND_N-1:0] pick_oh;
    logic [1:0]        top_idx;
    logic [1:0]        lft_idx;
    sem_sel_t          pick_sel;
    logic [ROW_W-1:0]  pick_row;
    logic [COL_W-1:0]  pick_col;
    logic              grad_start;
    logic [SUM_W-1:0]  grad_sum;
    logic              grad_valid;
    logic              root_start;
    logic [MAG_W-1:0]  root_val;
    logic              root_done;
    logic              ram_we;
    logic [LINE_W-1:0] ram_wdata;
    logic [LINE_W-1:0] ram_rdata;

    always_comb
    begin
        fw_ext = WCMP'(fw_reg);
        if (fw_ext < WCMP'(2))
            w_eff = WCMP'(2);
        else if (fw_ext > WCMP'(MAX_WIDTH))
            w_eff = WCMP'(MAX_WIDTH);
        else
            w_eff = fw_ext;
        fh_ext = HCMP'(fh_reg);
        if (fh_ext < HCMP'(2))
            h_eff = HCMP'(2);
        else if (fh_ext > HCMP'(MAX_HEIGHT))
            h_eff = HCMP'(MAX_HEIGHT);
        else
            h_eff = fh_ext;
        col_last = (WCMP'(col_reg) + WCMP'(1)) >= w_eff;
        row_last = (HCMP'(row_reg) + HCMP'(1)) >= h_eff;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // lowest pending candidate
    always_comb
    begin
        pick_oh = pres_reg & (~pres_reg + CAND_N'(1));
        top_idx = (item_row_reg == ROW_W'(1)) ? 2'd1 : 2'd0;
        lft_idx = (item_col_reg == COL_W'(1)) ? 2'd1 : 2'd0;
        if (pick_oh[CAND_CUR] || pick_oh[CAND_CURR])
        begin
            // last row replicates itself downward
            pick_sel.rt = 2'd1;
            pick_sel.rm = 2'd2;
            pick_sel.rb = 2'd2;
        end
        else
        begin
            pick_sel.rt = top_idx;
            pick_sel.rm = 2'd1;
            pick_sel.rb = 2'd2;
        end
        if (pick_oh[CAND_UPR] || pick_oh[CAND_CURR])
        begin
            pick_sel.cl = 2'd1;
            pick_sel.cm = 2'd2;
            pick_sel.cr = 2'd2;
        end
        else
        begin
            pick_sel.cl = lft_idx;
            pick_sel.cm = 2'd1;
            pick_sel.cr = 2'd2;
        end
        pick_row = (pick_oh[CAND_UP] || pick_oh[CAND_UPR])
                 ? item_row_reg - ROW_W'(1) : item_row_reg;
        pick_col = (pick_oh[CAND_UP] || pick_oh[CAND_CUR])
                 ? item_col_reg - COL_W'(1) : item_col_reg;
    end

    assign grad_start = (state_reg == ST_PICK) && (pres_reg != '0) && !pick_oh[CAND_HELD];
    assign root_start = (state_reg == ST_GRAD) && grad_valid;

    // line word: upper row in the high byte, middle row in the low byte
    assign ram_we    = (state_reg == ST_LOAD);
    assign ram_wdata = {ram_rdata[PIX_W-1:0], pix_reg};

    sem_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_col_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    sem_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (grad_start),
        .sel       (pick_sel),
        .win       (win_reg),
        .sum       (grad_sum),
        .sum_valid (grad_valid)
    );

    sem_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (grad_sum),
        .root     (root_val),
        .done     (root_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fw_reg         <= FRAME_WIDTH_W'(FRAME_WIDTH_RST);
            fh_reg         <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
            row_reg        <= '0;
            col_reg        <= '0;
            item_row_reg   <= '0;
            item_col_reg   <= '0;
            last_col_reg   <= 1'b0;
            last_row_reg   <= 1'b0;
            pix_reg        <= '0;
            win_reg        <= '0;
            pres_reg       <= '0;
            emit_cnt_reg   <= '0;
            held_valid_reg <= 1'b0;
            held_mag_reg   <= '0;
            held_row_reg   <= '0;
            held_col_reg   <= '0;
            cur_mag_reg    <= '0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_mag_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data[FRAME_WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data[FRAME_HEIGHT_W-1:0];
                    default:          ;
                endcase
            end

            // a word loaded in ST_EMIT takes the place of the one leaving
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_row_reg <= row_reg;
                        item_col_reg <= col_reg;
                        last_col_reg <= col_last;
                        last_row_reg <= row_last;
                        pix_reg      <= pixel_value;
                        if (col_last)
                        begin
                            col_reg <= '0;
                            row_reg <= row_last ? '0 : row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_reg <= col_reg + COL_W'(1);
                        end
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        win_reg[k*3]     <= win_reg[k*3+1];
                        win_reg[k*3 + 1] <= win_reg[k*3+2];
                    end
                    win_reg[2] <= ram_rdata[LINE_W-1:PIX_W];
                    win_reg[5] <= ram_rdata[PIX_W-1:0];
                    win_reg[8] <= pix_reg;
                    pres_reg[CAND_HELD] <= held_valid_reg;
                    pres_reg[CAND_UP]   <= (item_row_reg != '0) && (item_col_reg != '0);
                    pres_reg[CAND_UPR]  <= (item_row_reg != '0) && last_col_reg;
                    pres_reg[CAND_CUR]  <= last_row_reg && (item_col_reg != '0);
                    pres_reg[CAND_CURR] <= last_row_reg && last_col_reg;
                    held_valid_reg <= 1'b0;
                    emit_cnt_reg   <= '0;
                    state_reg      <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (pres_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        pres_reg <= pres_reg & ~pick_oh;
                        if (pick_oh[CAND_HELD])
                        begin
                            cur_mag_reg <= held_mag_reg;
                            cur_row_reg <= held_row_reg;
                            cur_col_reg <= held_col_reg;
                            state_reg   <= ST_EMIT;
                        end
                        else
                        begin
                            cur_row_reg <= pick_row;
                            cur_col_reg <= pick_col;
                            state_reg   <= ST_GRAD;
                        end
                    end
                end
                ST_GRAD:
                begin
                    if (grad_valid)
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (root_done)
                    begin
                        cur_mag_reg <= root_val;
                        if (emit_cnt_reg == 2'd3)
                        begin
                            // fourth word of a frame end waits for the next pixel
                            held_valid_reg <= 1'b1;
                            held_mag_reg   <= root_val;
                            held_row_reg   <= cur_row_reg;
                            held_col_reg   <= cur_col_reg;
                            state_reg      <= ST_PICK;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_mag_reg   <= cur_mag_reg;
                        out_row_reg   <= cur_row_reg;
                        out_col_reg   <= cur_col_reg;
                        out_last_reg  <= (emit_cnt_reg == 2'd2) || (pres_reg == '0);
                        emit_cnt_reg  <= emit_cnt_reg + 2'd1;
                        state_reg     <= ST_PICK;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_magnitude = out_mag_reg;
    assign out_row        = out_row_reg;
    assign out_col        = out_col_reg;
    assign last_in_run    = out_last_reg;

endmodule

### rtl/core/sem_checker.sv
// ----------------------------------------------------------------------------
// sem_checker: port-level checks for the sobel edge magnitude unit
// attached to the top level by bind
// ----------------------------------------------------------------------------
module sem_checker #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [sem_pkg::MAG_W-1:0]     edge_magnitude,
    input logic [$clog2(MAX_HEIGHT)-1:0] out_row,
    input logic [$clog2(MAX_WIDTH)-1:0]  out_col,
    input logic                          last_in_run
);

    // a stalled word keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(edge_magnitude)
            && $stable(out_row) && $stable(out_col) && $stable(last_in_run))
    else $error("output word changed while stalled");

    // one pixel at a time: no second pixel right behind an accepted one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("pixel taken on the cycle after a pixel");

    // a pixel's words are not yet complete, so no new pixel is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_in_run |-> !in_ready)
    else $error("pixel taken before the last word of a run");

    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
    else $error("output valid during reset");

endmodule

bind sobel_edge_magnitude_3x3_unit sem_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_sem_checker (.*);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sobel_edge_magnitude_3x3_unit
// streams raster frames of random pixels through the unit and checks every
// edge word against an in-bench sobel predictor with border replication,
// held bottom-right words, register clamping and mid-frame size changes
// ----------------------------------------------------------------------------
module testbench;

    import sem_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 64;
    localparam int ROW_W         = $clog2(MAX_HEIGHT_DEF);
    localparam int COL_W         = $clog2(MAX_WIDTH_DEF);

    typedef struct {
        logic [MAG_W-1:0] mag;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } edge_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel_value = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [MAG_W-1:0]     edge_magnitude;
    logic [ROW_W-1:0]     out_row;
    logic [COL_W-1:0]     out_col;
    logic                 last_in_run;

    // stimulus and expected words
    logic [PIX_W-1:0] pixel_feed[$];
    edge_word_t       edge_expect[$];
    edge_word_t       oldest_word;

    // predictor state
    logic [PIX_W-1:0]          upper_row_mem [0:MAX_WIDTH_DEF-1];
    logic [PIX_W-1:0]          middle_row_mem [0:MAX_WIDTH_DEF-1];
    logic [PIX_W-1:0]          win [0:WIN_N-1];
    logic [FRAME_WIDTH_W-1:0]  width_reg;
    logic [FRAME_HEIGHT_W-1:0] height_reg;
    int                        row_at;
    int                        col_at;
    bit                        held_valid;
    edge_word_t                held_word;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_pushed  = 0;
    int pixels_taken   = 0;
    int words_checked  = 0;
    int frames_done    = 0;
    int reg_writes     = 0;
    int failures       = 0;
    int quiet_cycles   = 0;

    sobel_edge_magnitude_3x3_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_value    (pixel_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .edge_magnitude (edge_magnitude),
        .out_row        (out_row),
        .out_col        (out_col),
        .last_in_run    (last_in_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int eff_width();
        if (width_reg < 2)
            return 2;
        if (width_reg > MAX_WIDTH_DEF)
            return MAX_WIDTH_DEF;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg < 2)
            return 2;
        if (height_reg > MAX_HEIGHT_DEF)
            return MAX_HEIGHT_DEF;
        return int'(height_reg);
    endfunction

    // pixels still needed to close the current frame at the present settings
    function automatic int frame_pixels_left();
        int w;
        int h;
        int here;
        w = eff_width();
        h = eff_height();
        here = (col_at >= w - 1) ? 1 : w - col_at;
        if (row_at + 1 >= h)
            return here;
        return here + (h - 1 - row_at) * w;
    endfunction

    function automatic int win_px(int rr, int cc);
        return int'(win[rr * 3 + cc]);
    endfunction

    // rounded, saturated gradient magnitude over chosen window rows and columns
    function automatic logic [MAG_W-1:0] grad_mag(int t, int m, int b, int l, int cc, int rr);
        int gx;
        int gy;
        int s;
        int n;
        gx = (win_px(t, l) + 2 * win_px(m, l) + win_px(b, l))
           - (win_px(t, rr) + 2 * win_px(m, rr) + win_px(b, rr));
        gy = (win_px(t, l) + 2 * win_px(t, cc) + win_px(t, rr))
           - (win_px(b, l) + 2 * win_px(b, cc) + win_px(b, rr));
        s = gx * gx + gy * gy;
        if (s > ROOT_CAP_SUM)
            return MAG_W'(MAG_SAT);
        n = 0;
        while ((n + 1) * (n + 1) <= s)
            n++;
        if (s > n * n + n)
            n++;
        return MAG_W'(n);
    endfunction

    task automatic sobel_step(input logic [PIX_W-1:0] px);
        edge_word_t found [0:4];
        int         n;
        int         emit;
        int         w;
        int         h;
        int         r;
        int         c;
        int         top;
        int         lft;
        bit         last_c;
        bit         last_r;
        n = 0;
        w = eff_width();
        h = eff_height();
        r = row_at;
        c = col_at;
        last_c = (c + 1 >= w);
        last_r = (r + 1 >= h);
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = upper_row_mem[c];
        win[5] = middle_row_mem[c];
        win[8] = px;
        upper_row_mem[c]  = middle_row_mem[c];
        middle_row_mem[c] = px;
        if (held_valid)
        begin
            found[n] = held_word;
            n++;
        end
        held_valid = 1'b0;
        // first row and first column replicate themselves
        top = (r == 1) ? 1 : 0;
        lft = (c == 1) ? 1 : 0;
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                found[n] = '{grad_mag(top, 1, 2, lft, 1, 2), ROW_W'(r - 1), COL_W'(c - 1), 1'b0};
                n++;
            end
            if (last_c)
            begin
                found[n] = '{grad_mag(top, 1, 2, 1, 2, 2), ROW_W'(r - 1), COL_W'(c), 1'b0};
                n++;
            end
        end
        if (last_r)
        begin
            if (c >= 1)
            begin
                found[n] = '{grad_mag(1, 2, 2, lft, 1, 2), ROW_W'(r), COL_W'(c - 1), 1'b0};
                n++;
            end
            if (last_c)
            begin
                found[n] = '{grad_mag(1, 2, 2, 1, 2, 2), ROW_W'(r), COL_W'(c), 1'b0};
                n++;
            end
        end
        // bottom-right word of a frame waits for the next pixel
        emit = (n > 3) ? 3 : n;
        if (n > 3)
        begin
            held_word  = found[3];
            held_valid = 1'b1;
        end
        for (int k = 0; k < emit; k++)
        begin
            found[k].last = (k == emit - 1);
            edge_expect.push_back(found[k]);
        end
        if (last_c)
        begin
            col_at = 0;
            row_at = last_r ? 0 : r + 1;
            if (last_r)
                frames_done++;
        end
        else
            col_at = c + 1;
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("%s", what);
    endtask

    task automatic feed_pixel(input logic [PIX_W-1:0] px);
        pixel_feed.push_back(px);
        pixels_pushed++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(int style);
        case (style)
            1:       return $urandom_range(1) ? 8'd255 : 8'd0;
            2:       return PIX_W'($urandom_range(140, 100));
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic write_reg(input sem_reg_idx_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = value[FRAME_WIDTH_W-1:0];
        else
            height_reg = value[FRAME_HEIGHT_W-1:0];
        reg_writes++;
    endtask

    // every pixel taken, every word seen, then let the pipe drain
    task automatic wait_idle();
        while (pixels_taken != pixels_pushed || edge_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_frame();
        int w;
        int style;
        int total;
        int cut;
        wait_idle();
        if ($urandom_range(3) != 0)
        begin
            if ($urandom_range(9) == 0)
                w = $urandom_range(1);
            else if ($urandom_range(7) == 0)
                w = $urandom_range(32, 9);
            else
                w = $urandom_range(8, 2);
            // bits above the width field are ignored
            write_reg(REG_FRAME_WIDTH, {2'($urandom_range(3)), FRAME_WIDTH_W'(w)});
            write_reg(REG_FRAME_HEIGHT,
                      CFG_W'(($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(6, 2)));
        end
        style = $urandom_range(3);
        total = frame_pixels_left();
        cut = ($urandom_range(4) == 0) ? $urandom_range(total - 1, 1) : total;
        for (int k = 0; k < cut; k++)
            feed_pixel(pick_pixel(style));
        if (cut < total)
        begin
            // sender holds off mid-frame until all words are back, then resizes
            wait_idle();
            if ($urandom_range(1) != 0)
                write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(6, 2)));
            else
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(eff_width(), 2)));
            total = frame_pixels_left();
            for (int k = 0; k < total; k++)
                feed_pixel(pick_pixel(style));
        end
        else if ($urandom_range(2) == 0)
        begin
            // a second frame right behind, same size
            for (int k = 0; k < eff_width() * eff_height(); k++)
                feed_pixel(pick_pixel($urandom_range(3)));
        end
    endtask

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            pixel_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                sobel_step(pixel_value);
                pixels_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    pixel_value <= pixel_feed.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // edge word monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                words_checked++;
                if (edge_expect.size() == 0)
                    note_failure($sformatf("unexpected word: mag %0d row %0d col %0d last %0d",
                                           edge_magnitude, out_row, out_col, last_in_run));
                else
                begin
                    oldest_word = edge_expect.pop_front();
                    if (edge_magnitude !== oldest_word.mag || out_row !== oldest_word.row ||
                        out_col !== oldest_word.col || last_in_run !== oldest_word.last)
                        note_failure({
                            $sformatf("word mismatch: expected mag %0d row %0d col %0d last %0d,",
                                      oldest_word.mag, oldest_word.row, oldest_word.col,
                                      oldest_word.last),
                            $sformatf(" got mag %0d row %0d col %0d last %0d",
                                      edge_magnitude, out_row, out_col, last_in_run)});
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        for (int k = 0; k < MAX_WIDTH_DEF; k++)
        begin
            upper_row_mem[k]  = '0;
            middle_row_mem[k] = '0;
        end
        for (int k = 0; k < WIN_N; k++)
            win[k] = '0;
        width_reg  = FRAME_WIDTH_W'(FRAME_WIDTH_RST);
        height_reg = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
        row_at     = 0;
        col_at     = 0;
        held_valid = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few pixels at the reset size, then shrink to the clamped minimum mid-row
        feed_pixel(8'd255);
        feed_pixel(8'd0);
        feed_pixel(8'd255);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(0));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        feed_pixel(8'd0);
        feed_pixel(8'd255);
        feed_pixel(8'd255);
        // 2x2 frame, four words for its last pixel
        feed_pixel(8'd0);
        feed_pixel(8'd255);
        feed_pixel(8'd255);
        feed_pixel(8'd0);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
        // vertical edge, saturating gx; pause mid-frame until drained
        for (int k = 0; k < 9; k++)
        begin
            feed_pixel((k % 3 == 2) ? 8'd0 : 8'd255);
            if (k == 4)
                wait_idle();
        end
        // horizontal edge on the bottom row
        for (int k = 0; k < 9; k++)
            feed_pixel((k >= 6) ? 8'd255 : 8'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            int start;
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            start = pixels_pushed;
            while (pixels_pushed - start < 70)
                random_frame();
        end

        // one more pixel releases a held bottom-right word
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        feed_pixel(8'd77);
        wait_idle();

        if (edge_expect.size() != 0)
            note_failure($sformatf("%0d expected words never arrived", edge_expect.size()));
        $display("covered %0d pixels over %0d frames, %0d edge words checked, %0d register writes",
                 pixels_taken, frames_done, words_checked, reg_writes);
        $display("sizes from the clamped 2x2 minimum up to 32 wide, mid-frame resizes, four idle mixes");
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
